// ===== hdl/bpte_pkg.sv =====
// Package for the button press timer events unit: field widths, register
// indexes, threshold and result types. No dependencies.
`default_nettype none
package bpte_pkg;

  localparam int TIMER_W   = 15;
  localparam int LEVEL_W   = 3;
  localparam int ELAPSED_W = 16;
  localparam int FIELD_W   = 3;
  localparam int SUM_W     = ELAPSED_W + 1;

  localparam logic [TIMER_W-1:0] TIMER_MAX       = 15'h7FFF;
  localparam logic [TIMER_W-1:0] PRESS_THR_RST   = 15'd50;
  localparam logic [TIMER_W-1:0] LONG_THR_RST    = 15'd1000;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_PRESS_THR = 1'b0,
    REG_LONG_THR  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TIMER_W-1:0] press_thr;
    logic [TIMER_W-1:0] long_thr;
  } thr_cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] press_events;
    logic [FIELD_W-1:0] release_events;
    logic [FIELD_W-1:0] long_press_events;
    logic [FIELD_W-1:0] held_mask;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/bpte_update.sv =====
// Per-item timer update: press/release/long-press detection, saturation,
// chord equalization and held mask. Combinational. Depends on bpte_pkg.
`default_nettype none
module bpte_update #(
  parameter int NUM_BUTTONS = 3
) (
  input  wire logic [bpte_pkg::LEVEL_W-1:0]                      button_levels,
  input  wire logic [bpte_pkg::ELAPSED_W-1:0]                    elapsed_ticks,
  input  wire bpte_pkg::thr_cfg_t                                cfg,
  input  wire logic [NUM_BUTTONS-1:0][bpte_pkg::TIMER_W-1:0]     timers,
  output      logic [NUM_BUTTONS-1:0][bpte_pkg::TIMER_W-1:0]     timers_next,
  output      bpte_pkg::result_t                                 res
);

  logic [NUM_BUTTONS-1:0]                         lv;
  logic [NUM_BUTTONS-1:0]                         press_ev;
  logic [NUM_BUTTONS-1:0]                         release_ev;
  logic [NUM_BUTTONS-1:0]                         long_ev;
  logic [NUM_BUTTONS-1:0]                         held;
  logic [NUM_BUTTONS-1:0][bpte_pkg::TIMER_W-1:0]  upd;
  logic [bpte_pkg::SUM_W-1:0]                     sum;
  logic [bpte_pkg::SUM_W-1:0]                     t_ext;
  logic [bpte_pkg::SUM_W-1:0]                     pt_ext;
  logic [bpte_pkg::SUM_W-1:0]                     lt_ext;
  logic [bpte_pkg::TIMER_W-1:0]                   min_t;
  logic                                           any;

  always_comb begin
    pt_ext = {2'b00, cfg.press_thr};
    lt_ext = {2'b00, cfg.long_thr};
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      // buttons past the input field see a pressed level
      lv[i]         = (i < bpte_pkg::LEVEL_W) ? button_levels[i % bpte_pkg::LEVEL_W] : 1'b0;
      press_ev[i]   = 1'b0;
      release_ev[i] = 1'b0;
      long_ev[i]    = 1'b0;
      t_ext = {2'b00, timers[i]};
      sum   = t_ext + {1'b0, elapsed_ticks};
      if (lv[i]) begin
        release_ev[i] = (t_ext >= pt_ext) && (t_ext < lt_ext);
        upd[i] = '0;
      end else begin
        if ((t_ext < pt_ext) && (sum >= pt_ext)) begin
          press_ev[i] = 1'b1;
        end else if ((t_ext < lt_ext) && (sum >= lt_ext)) begin
          long_ev[i] = 1'b1;
        end
        upd[i] = (sum > {2'b00, bpte_pkg::TIMER_MAX}) ? bpte_pkg::TIMER_MAX
                                                       : sum[bpte_pkg::TIMER_W-1:0];
      end
    end

    min_t = '0;
    any   = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if ((upd[i] != '0) && (!any || (upd[i] < min_t))) begin
        min_t = upd[i];
        any   = 1'b1;
      end
    end

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      timers_next[i] = (upd[i] != '0) ? min_t : '0;
      held[i]        = timers_next[i] > cfg.long_thr;
    end

    for (int j = 0; j < bpte_pkg::FIELD_W; j++) begin
      if (j < NUM_BUTTONS) begin
        res.press_events[j]      = press_ev[j % NUM_BUTTONS];
        res.release_events[j]    = release_ev[j % NUM_BUTTONS];
        res.long_press_events[j] = long_ev[j % NUM_BUTTONS];
        res.held_mask[j]         = held[j % NUM_BUTTONS];
      end else begin
        res.press_events[j]      = 1'b0;
        res.release_events[j]    = 1'b0;
        res.long_press_events[j] = 1'b0;
        res.held_mask[j]         = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/button_press_timer_events_unit.sv =====
// Button press timer events unit: threshold registers on an APB-style port,
// per-button hold timers, two-entry output buffer. Uses bpte_pkg, bpte_update.
// Accepted results go to the output register, or to the skid entry on a stall.
// Throughput: one item per cycle while in_ready is high; the timer update is a
// single pass from the input ports into the timer and result registers.
// Reset: timers clear, thresholds return to 50 and 1000, output buffer empties.
`default_nettype none
module button_press_timer_events_unit #(
  parameter int NUM_BUTTONS = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bpte_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bpte_pkg::PDATA_W-1:0]    pwdata,
  output      logic [bpte_pkg::PDATA_W-1:0]    prdata,
  output      logic                            pready,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [bpte_pkg::LEVEL_W-1:0]    button_levels,
  input  wire logic [bpte_pkg::ELAPSED_W-1:0]  elapsed_ticks,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [bpte_pkg::FIELD_W-1:0]    press_events,
  output      logic [bpte_pkg::FIELD_W-1:0]    release_events,
  output      logic [bpte_pkg::FIELD_W-1:0]    long_press_events,
  output      logic [bpte_pkg::FIELD_W-1:0]    held_mask
);

  bpte_pkg::thr_cfg_t                              cfg;
  bpte_pkg::reg_idx_t                              reg_idx;
  logic [NUM_BUTTONS-1:0][bpte_pkg::TIMER_W-1:0]   timers;
  logic [NUM_BUTTONS-1:0][bpte_pkg::TIMER_W-1:0]   timers_next;
  bpte_pkg::result_t                               res_next;
  bpte_pkg::result_t                               out_res;
  bpte_pkg::result_t                               skid_res;
  logic                                            skid_valid;
  logic                                            cfg_wr;
  logic                                            in_acc;
  logic                                            out_free;

  assign pready  = 1'b1;
  assign reg_idx = bpte_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      bpte_pkg::REG_PRESS_THR: prdata = {17'd0, cfg.press_thr};
      bpte_pkg::REG_LONG_THR:  prdata = {17'd0, cfg.long_thr};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_thr <= bpte_pkg::PRESS_THR_RST;
      cfg.long_thr  <= bpte_pkg::LONG_THR_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bpte_pkg::REG_PRESS_THR: cfg.press_thr <= pwdata[bpte_pkg::TIMER_W-1:0];
        bpte_pkg::REG_LONG_THR:  cfg.long_thr  <= pwdata[bpte_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  bpte_update #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_update (
    .button_levels (button_levels),
    .elapsed_ticks (elapsed_ticks),
    .cfg           (cfg),
    .timers        (timers),
    .timers_next   (timers_next),
    .res           (res_next)
  );

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timers <= '0;
    end else if (in_acc) begin
      timers <= timers_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_acc) begin
        out_res <= res_next;
      end
    end else if (in_acc) begin
      skid_res <= res_next;
    end
  end

  assign press_events      = out_res.press_events;
  assign release_events    = out_res.release_events;
  assign long_press_events = out_res.long_press_events;
  assign held_mask         = out_res.held_mask;

endmodule
`default_nettype wire
